// ----- rtl/utsan_pkg.sv -----
package utsan_pkg;

	localparam logic [7:0] CH_BSL = 8'h5c;
	localparam logic [7:0] CH_X   = 8'h78;
	localparam logic [7:0] CH_U   = 8'h75;
	localparam logic [7:0] CH_N   = 8'h6e;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_T   = 8'h74;

	localparam logic [20:0] CP_TAB    = 21'h00009;
	localparam logic [20:0] CP_LF     = 21'h0000a;
	localparam logic [20:0] CP_CR     = 21'h0000d;
	localparam logic [20:0] CP_SPACE  = 21'h00020;
	localparam logic [20:0] CP_DEL    = 21'h0007f;
	localparam logic [20:0] CP_C1_END = 21'h0009f;
	localparam logic [20:0] CP_LSEP   = 21'h02028;
	localparam logic [20:0] CP_PSEP   = 21'h02029;
	localparam logic [20:0] CP_EMB_LO = 21'h0202a;
	localparam logic [20:0] CP_EMB_HI = 21'h0202e;
	localparam logic [20:0] CP_ISO_LO = 21'h02066;
	localparam logic [20:0] CP_ISO_HI = 21'h02069;

	localparam logic [7:0] B_LEAD2_LO = 8'hc2;
	localparam logic [7:0] B_LEAD2_HI = 8'hdf;
	localparam logic [7:0] B_LEAD3_LO = 8'he0;
	localparam logic [7:0] B_LEAD3_HI = 8'hef;
	localparam logic [7:0] B_LEAD4_LO = 8'hf0;
	localparam logic [7:0] B_LEAD4_HI = 8'hf4;
	localparam logic [7:0] B_LEAD_SUR = 8'hed;
	localparam logic [7:0] B_CONT_LO  = 8'h80;
	localparam logic [7:0] B_CONT_HI  = 8'hbf;
	localparam logic [7:0] B_E0_LO    = 8'ha0;
	localparam logic [7:0] B_F0_LO    = 8'h90;
	localparam logic [7:0] B_ED_HI    = 8'h9f;
	localparam logic [7:0] B_F4_HI    = 8'h8f;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       text_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_done;
	} out_item_t;

	typedef enum logic [1:0] {
		MK_NONE,
		MK_ESC,
		MK_HEX4,
		MK_RAW
	} main_kind_t;

	// hex escapes: pend[0..hx_k-1], then extra if extra_v; then the main part
	typedef struct packed {
		logic [2:0][7:0] pend;
		logic [1:0]      hx_k;
		logic            extra_v;
		logic [7:0]      extra;
		main_kind_t      kind;
		logic [2:0]      mlen;
		logic [3:0][7:0] mdat;
		logic            last;
	} job_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] d;
		if (n < 4'd10) begin
			d = 8'h30 + {4'd0, n};
		end else begin
			d = 8'h57 + {4'd0, n};
		end
		return d;
	endfunction

endpackage

// ----- rtl/utsan_front.sv -----
module utsan_front (
	input  logic                clk,
	input  logic                arst_n,
	input  utsan_pkg::in_item_t item,
	input  logic                accept,
	output utsan_pkg::job_t     job,
	output logic                job_nonempty
);
	import utsan_pkg::*;

	logic [2:0][7:0] pend_q;
	logic [1:0]      cnt_q;
	logic [2:0]      len_q;

	logic [2:0][7:0] pend_d;
	logic [1:0]      cnt_d;
	logic [2:0]      len_d;

	logic [7:0]  b;
	logic        last;
	logic        ok, flush, start, buf_cont, complete;
	logic        start_lead, start_ascii, start_bad, have_cp;
	logic [2:0]  lead_len;
	logic [20:0] cp;
	logic [3:0][7:0] seq;
	logic [2:0]  seq_len;

	function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
			input logic [7:0] c);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = B_CONT_LO;
		hi = B_CONT_HI;
		if (pos == 2'd1) begin
			if (lead == B_LEAD3_LO) lo = B_E0_LO;
			else if (lead == B_LEAD4_LO) lo = B_F0_LO;
			if (lead == B_LEAD_SUR) hi = B_ED_HI;
			else if (lead == B_LEAD4_HI) hi = B_F4_HI;
		end
		return (c >= lo) && (c <= hi);
	endfunction

	always_comb begin
		b    = item.in_byte;
		last = item.text_last;

		ok       = (cnt_q != 2'd0) && cont_ok(pend_q[0], cnt_q, b);
		flush    = (cnt_q != 2'd0) && !ok;
		start    = !ok;
		buf_cont = ok && (({1'b0, cnt_q} + 3'd1) < len_q);
		complete = ok && !buf_cont;

		if (b >= B_LEAD2_LO && b <= B_LEAD2_HI) lead_len = 3'd2;
		else if (b >= B_LEAD3_LO && b <= B_LEAD3_HI) lead_len = 3'd3;
		else if (b >= B_LEAD4_LO && b <= B_LEAD4_HI) lead_len = 3'd4;
		else lead_len = 3'd0;

		start_ascii = start && !b[7];
		start_lead  = start && (lead_len != 3'd0);
		start_bad   = start && b[7] && (lead_len == 3'd0);
		have_cp     = start_ascii || complete;

		seq = '0;
		if (start_ascii) begin
			cp      = {13'd0, b};
			seq[0]  = b;
			seq_len = 3'd1;
		end else begin
			case (len_q)
				3'd2: begin
					cp      = {10'd0, pend_q[0][4:0], b[5:0]};
					seq[0]  = pend_q[0];
					seq[1]  = b;
					seq_len = 3'd2;
				end
				3'd3: begin
					cp      = {5'd0, pend_q[0][3:0], pend_q[1][5:0], b[5:0]};
					seq[0]  = pend_q[0];
					seq[1]  = pend_q[1];
					seq[2]  = b;
					seq_len = 3'd3;
				end
				default: begin
					cp      = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], b[5:0]};
					seq[0]  = pend_q[0];
					seq[1]  = pend_q[1];
					seq[2]  = pend_q[2];
					seq[3]  = b;
					seq_len = 3'd4;
				end
			endcase
		end

		job.pend    = pend_q;
		job.hx_k    = (flush || (last && buf_cont)) ? cnt_q : 2'd0;
		job.extra_v = 1'b0;
		job.extra   = b;
		job.kind    = MK_NONE;
		job.mlen    = seq_len;
		job.mdat    = seq;
		job.last    = last;

		if (have_cp) begin
			if (cp == CP_LF) begin
				job.kind    = MK_ESC;
				job.mdat[0] = CH_N;
			end else if (cp == CP_CR) begin
				job.kind    = MK_ESC;
				job.mdat[0] = CH_R;
			end else if (cp == CP_TAB) begin
				job.kind    = MK_ESC;
				job.mdat[0] = CH_T;
			end else if (cp < CP_SPACE || (cp >= CP_DEL && cp <= CP_C1_END)) begin
				job.extra_v = 1'b1;
				job.extra   = cp[7:0];
			end else if (cp == CP_LSEP || cp == CP_PSEP ||
					(cp >= CP_EMB_LO && cp <= CP_EMB_HI) ||
					(cp >= CP_ISO_LO && cp <= CP_ISO_HI)) begin
				job.kind    = MK_HEX4;
				job.mdat[0] = cp[15:8];
				job.mdat[1] = cp[7:0];
			end else begin
				job.kind = MK_RAW;
			end
		end
		if (start_bad || (last && (start_lead || buf_cont))) begin
			job.extra_v = 1'b1;
			job.extra   = b;
		end

		job_nonempty = job.extra_v || (job.hx_k != 2'd0) || (job.kind != MK_NONE);

		pend_d = pend_q;
		cnt_d  = 2'd0;
		len_d  = 3'd0;
		if (start_lead) begin
			pend_d[0] = b;
			cnt_d     = 2'd1;
			len_d     = lead_len;
		end else if (buf_cont) begin
			case (cnt_q)
				2'd1:    pend_d[1] = b;
				default: pend_d[2] = b;
			endcase
			cnt_d = cnt_q + 2'd1;
			len_d = len_q;
		end
		if (last) begin
			cnt_d = 2'd0;
			len_d = 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			len_q <= 3'd0;
		end else if (accept) begin
			cnt_q <= cnt_d;
			len_q <= len_d;
		end
	end

`ifndef SYNTHESIS
	a_len_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> (len_q > {1'b0, cnt_q}) && (len_q <= 3'd4))
		else $error("pending count does not fit sequence length");

	a_idle_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (len_q == 3'd0))
		else $error("sequence length set with empty buffer");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.text_last) |=> (cnt_q == 2'd0))
		else $error("buffer not empty after final byte");
`endif

endmodule

// ----- rtl/utsan_fifo.sv -----
module utsan_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  utsan_pkg::job_t push_data,
	output logic            full,
	input  logic            pop,
	output utsan_pkg::job_t head,
	output logic            nonempty
);
	import utsan_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t            mem [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/utsan_back.sv -----
module utsan_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utsan_pkg::job_t      head,
	input  logic                 head_valid,
	output logic                 pop,
	output logic                 valid,
	input  logic                 stall,
	output utsan_pkg::out_item_t item
);
	import utsan_pkg::*;

	job_t       cur_q;
	logic       cur_v_q;
	logic [3:0] pos_q;

	logic [2:0] hx_cnt;
	logic [4:0] hexbase;
	logic [2:0] main_len;
	logic [4:0] total;
	logic [4:0] pos5;
	logic [4:0] mp5;
	logic [2:0] mp;
	logic [7:0] hv;
	logic [7:0] ob;
	logic       last_byte;
	logic       accept;
	logic       load;

	always_comb begin
		hx_cnt  = {1'b0, cur_q.hx_k} + {2'd0, cur_q.extra_v};
		hexbase = {hx_cnt, 2'b00};
		case (cur_q.kind)
			MK_ESC:  main_len = 3'd2;
			MK_HEX4: main_len = 3'd6;
			MK_RAW:  main_len = cur_q.mlen;
			default: main_len = 3'd0;
		endcase
		total = hexbase + {2'd0, main_len};
		pos5  = {1'b0, pos_q};
		mp5   = pos5 - hexbase;
		mp    = mp5[2:0];

		case (pos_q[3:2])
			2'd0:    hv = (cur_q.hx_k > 2'd0) ? cur_q.pend[0] : cur_q.extra;
			2'd1:    hv = (cur_q.hx_k > 2'd1) ? cur_q.pend[1] : cur_q.extra;
			2'd2:    hv = (cur_q.hx_k > 2'd2) ? cur_q.pend[2] : cur_q.extra;
			default: hv = cur_q.extra;
		endcase

		if (pos5 < hexbase) begin
			case (pos_q[1:0])
				2'd0:    ob = CH_BSL;
				2'd1:    ob = CH_X;
				2'd2:    ob = hex_digit(hv[7:4]);
				default: ob = hex_digit(hv[3:0]);
			endcase
		end else begin
			case (cur_q.kind)
				MK_ESC: begin
					ob = (mp == 3'd0) ? CH_BSL : cur_q.mdat[0];
				end
				MK_HEX4: begin
					case (mp)
						3'd0:    ob = CH_BSL;
						3'd1:    ob = CH_U;
						3'd2:    ob = hex_digit(cur_q.mdat[0][7:4]);
						3'd3:    ob = hex_digit(cur_q.mdat[0][3:0]);
						3'd4:    ob = hex_digit(cur_q.mdat[1][7:4]);
						default: ob = hex_digit(cur_q.mdat[1][3:0]);
					endcase
				end
				default: ob = cur_q.mdat[mp[1:0]];
			endcase
		end

		last_byte      = (pos5 == total - 5'd1);
		item.out_byte  = ob;
		item.run_last  = last_byte;
		item.text_done = last_byte && cur_q.last;
		valid          = cur_v_q;
		accept         = cur_v_q && !stall;
		load           = !cur_v_q || (accept && last_byte);
		pop            = load && head_valid;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			pos_q   <= 4'd0;
		end else if (load) begin
			cur_v_q <= head_valid;
			pos_q   <= 4'd0;
		end else if (accept) begin
			pos_q <= pos_q + 4'd1;
		end
	end

`ifndef SYNTHESIS
	a_pos_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> ({1'b0, pos_q} < total))
		else $error("byte position beyond job length");

	a_job_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !last_byte) |=> cur_v_q && (pos_q == $past(pos_q) + 4'd1))
		else $error("job dropped before its last byte");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_v_q && stall) |=> cur_v_q && $stable(pos_q))
		else $error("position moved while stalled");
`endif

endmodule

// ----- rtl/utf8_terminal_sanitizer.sv -----
// UTF-8 terminal sanitizer.
// Input channel raw (raw_valid / raw_stall): one text byte per transaction,
// text_last marks the final byte of a text. Output channel safe
// (safe_valid / safe_stall): one sanitized byte per transaction; run_last
// marks the last byte caused by one input byte, text_done the last byte of
// the text. Input bytes that only extend a pending sequence yield no output.
// The first output byte of an input byte passes the job queue register and is
// then registered into the expansion stage. Throughput: one input byte per
// cycle while each yields at most one output byte and safe_stall is low; an
// input byte may yield up to 16 output bytes, which the expansion stage sends
// one per cycle while safe_stall is low. A queue of QUEUE_DEPTH decoded jobs
// separates decode and expansion, so input keeps flowing during escapes
// until the queue fills, then raw_stall rises.
// Reset empties the pending sequence buffer and the queue; no output is
// valid afterwards. While safe_stall is high the current byte holds.
module utf8_terminal_sanitizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 raw_valid,
	output logic                 raw_stall,
	input  utsan_pkg::in_item_t  raw,
	output logic                 safe_valid,
	input  logic                 safe_stall,
	output utsan_pkg::out_item_t safe
);
	import utsan_pkg::*;

	job_t job;
	job_t head;
	logic job_nonempty;
	logic full;
	logic head_valid;
	logic pop;
	logic accept;

	assign raw_stall = full;
	assign accept    = raw_valid && !full;

	utsan_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (raw),
		.accept       (accept),
		.job          (job),
		.job_nonempty (job_nonempty)
	);

	utsan_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && job_nonempty),
		.push_data (job),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.nonempty  (head_valid)
	);

	utsan_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.valid      (safe_valid),
		.stall      (safe_stall),
		.item       (safe)
	);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import utsan_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      raw_valid = 1'b0;
	logic      raw_stall;
	in_item_t  raw = '0;
	logic      safe_valid;
	logic      safe_stall = 1'b0;
	out_item_t safe;

	utf8_terminal_sanitizer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw_valid  (raw_valid),
		.raw_stall  (raw_stall),
		.raw        (raw),
		.safe_valid (safe_valid),
		.safe_stall (safe_stall),
		.safe       (safe)
	);

	always #1 clk = ~clk;

	// decoder state of the predictor
	logic [7:0]  seq_buf [3];
	int unsigned seq_have = 0;
	int unsigned seq_need = 0;

	logic [7:0]  step_bytes [$];
	out_item_t   expected_out [$];
	logic [7:0]  burst [$];
	int          mismatches = 0;
	int unsigned bytes_sent = 0;
	bit          gaps_on = 1'b1;
	bit          stalls_on = 1'b1;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40) begin
			$display("%0t mismatch: %s", $realtime, what);
		end
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		string digits;
		digits = "0123456789abcdef";
		return digits[n];
	endfunction

	task automatic put_hex2(input logic [7:0] v);
		step_bytes.push_back(CH_BSL);
		step_bytes.push_back(CH_X);
		step_bytes.push_back(hex_char(v[7:4]));
		step_bytes.push_back(hex_char(v[3:0]));
	endtask

	task automatic put_hex4(input logic [20:0] cp);
		step_bytes.push_back(CH_BSL);
		step_bytes.push_back(CH_U);
		step_bytes.push_back(hex_char(cp[15:12]));
		step_bytes.push_back(hex_char(cp[11:8]));
		step_bytes.push_back(hex_char(cp[7:4]));
		step_bytes.push_back(hex_char(cp[3:0]));
	endtask

	task automatic put_code_point(input logic [20:0] cp, input logic [3:0][7:0] enc,
			input int unsigned len);
		if (cp == CP_LF) begin
			step_bytes.push_back(CH_BSL);
			step_bytes.push_back(CH_N);
		end else if (cp == CP_CR) begin
			step_bytes.push_back(CH_BSL);
			step_bytes.push_back(CH_R);
		end else if (cp == CP_TAB) begin
			step_bytes.push_back(CH_BSL);
			step_bytes.push_back(CH_T);
		end else if (cp < CP_SPACE || (cp >= CP_DEL && cp <= CP_C1_END)) begin
			put_hex2(cp[7:0]);
		end else if (cp == CP_LSEP || cp == CP_PSEP ||
				(cp >= CP_EMB_LO && cp <= CP_EMB_HI) ||
				(cp >= CP_ISO_LO && cp <= CP_ISO_HI)) begin
			put_hex4(cp);
		end else begin
			for (int i = 0; i < len; i++) step_bytes.push_back(enc[i]);
		end
	endtask

	task automatic flush_pending();
		for (int i = 0; i < seq_have; i++) put_hex2(seq_buf[i]);
		seq_have = 0;
		seq_need = 0;
	endtask

	function automatic bit cont_ok(input logic [7:0] lead, input int unsigned pos,
			input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = B_CONT_LO;
		hi = B_CONT_HI;
		if (pos == 1) begin
			if (lead == B_LEAD3_LO) lo = B_E0_LO;
			else if (lead == B_LEAD4_LO) lo = B_F0_LO;
			if (lead == B_LEAD_SUR) hi = B_ED_HI;
			else if (lead == B_LEAD4_HI) hi = B_F4_HI;
		end
		return b >= lo && b <= hi;
	endfunction

	task automatic start_byte(input logic [7:0] b);
		if (b < B_CONT_LO) begin
			put_code_point({13'd0, b}, {24'd0, b}, 1);
		end else if (b >= B_LEAD2_LO && b <= B_LEAD2_HI) begin
			seq_buf[0] = b;
			seq_have = 1;
			seq_need = 2;
		end else if (b >= B_LEAD3_LO && b <= B_LEAD3_HI) begin
			seq_buf[0] = b;
			seq_have = 1;
			seq_need = 3;
		end else if (b >= B_LEAD4_LO && b <= B_LEAD4_HI) begin
			seq_buf[0] = b;
			seq_have = 1;
			seq_need = 4;
		end else begin
			put_hex2(b);
		end
	endtask

	task automatic continue_byte(input logic [7:0] b);
		logic [3:0][7:0] enc;
		logic [20:0]     cp;
		int unsigned     len;
		len = seq_need;
		if (!cont_ok(seq_buf[0], seq_have, b)) begin
			flush_pending();
			start_byte(b);
		end else if (seq_have + 1 < len) begin
			seq_buf[seq_have] = b;
			seq_have++;
		end else begin
			enc = '0;
			for (int i = 0; i < seq_have; i++) enc[i] = seq_buf[i];
			enc[seq_have] = b;
			case (len)
			2: cp = {10'd0, enc[0][4:0], enc[1][5:0]};
			3: cp = {5'd0, enc[0][3:0], enc[1][5:0], enc[2][5:0]};
			default: cp = {enc[0][2:0], enc[1][5:0], enc[2][5:0], enc[3][5:0]};
			endcase
			seq_have = 0;
			seq_need = 0;
			put_code_point(cp, enc, len);
		end
	endtask

	task automatic sanitize_byte(input logic [7:0] b, input logic last);
		out_item_t r;
		step_bytes.delete();
		if (seq_have == 0) start_byte(b);
		else continue_byte(b);
		if (last) flush_pending();
		foreach (step_bytes[i]) begin
			r.out_byte  = step_bytes[i];
			r.run_last  = (i == step_bytes.size() - 1);
			r.text_done = last && r.run_last;
			expected_out.push_back(r);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (gaps_on && $urandom_range(0, 99) < 33) begin
			raw_valid <= 1'b0;
			@(posedge clk);
		end
		raw_valid <= 1'b1;
		raw <= '{in_byte: b, text_last: last};
		sanitize_byte(b, last);
		bytes_sent++;
		do @(posedge clk); while (raw_stall);
	endtask

	task automatic send_burst(input bit end_last, input int unsigned last_pct);
		foreach (burst[i]) begin
			send_byte(burst[i], (end_last && i == burst.size() - 1) ||
				$urandom_range(0, 99) < last_pct);
		end
	endtask

	// one character: mostly well formed, some overlong, truncated, corrupted or noise
	task automatic make_unit();
		int unsigned pick;
		int unsigned len;
		int unsigned idx;
		logic [20:0] cp;
		burst.delete();
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			burst.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 28))
				0: cp = CP_TAB;
				1: cp = CP_LF;
				2: cp = CP_CR;
				3: cp = 21'h00000;
				4: cp = 21'h0001f;
				5: cp = CP_DEL;
				6: cp = 21'h00080;
				7: cp = CP_C1_END;
				8: cp = 21'h000a0;
				9: cp = CP_LSEP;
				10: cp = CP_PSEP;
				11: cp = CP_EMB_LO;
				12: cp = CP_EMB_HI;
				13: cp = CP_ISO_LO;
				14: cp = CP_ISO_HI;
				15: cp = 21'h02027;
				16: cp = 21'h0202f;
				17: cp = 21'h02065;
				18: cp = 21'h0206a;
				19: cp = 21'h007ff;
				20: cp = 21'h00800;
				21: cp = 21'h0d7ff;
				22: cp = 21'h0d800;
				23: cp = 21'h0dfff;
				24: cp = 21'h0e000;
				25: cp = 21'h0ffff;
				26: cp = 21'h10000;
				27: cp = 21'h10ffff;
				default: cp = 21'h110000;
				endcase
				len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
			end else begin
				len = $urandom_range(1, 4);
				case (len)
				1: cp = 21'($urandom_range(0, 'h7f));
				2: cp = 21'($urandom_range('h80, 'h7ff));
				3: cp = 21'($urandom_range('h800, 'hffff));
				default: cp = ($urandom_range(0, 9) == 0) ?
					21'($urandom_range('h110000, 'h1fffff)) :
					21'($urandom_range('h10000, 'h10ffff));
				endcase
			end
			if (pick < 25 && len < 4) len++;
			case (len)
			1: burst.push_back(cp[7:0]);
			2: begin
				burst.push_back({3'b110, cp[10:6]});
				burst.push_back({2'b10, cp[5:0]});
			end
			3: begin
				burst.push_back({4'b1110, cp[15:12]});
				burst.push_back({2'b10, cp[11:6]});
				burst.push_back({2'b10, cp[5:0]});
			end
			default: begin
				burst.push_back({5'b11110, cp[20:18]});
				burst.push_back({2'b10, cp[17:12]});
				burst.push_back({2'b10, cp[11:6]});
				burst.push_back({2'b10, cp[5:0]});
			end
			endcase
			if (pick >= 25 && pick < 35 && burst.size() > 1) begin
				idx = $urandom_range(1, burst.size() - 1);
				while (burst.size() > idx) void'(burst.pop_back());
			end else if (pick >= 35 && pick < 42) begin
				idx = $urandom_range(0, burst.size() - 1);
				burst[idx] = 8'($urandom_range(0, 255));
			end
		end
	endtask

	task automatic test_controls();
		burst = {8'h00, 8'h0a, 8'h0d, 8'h09, 8'h1f, 8'h7f, 8'h41};
		send_burst(1'b0, 0);
	endtask

	task automatic test_sequences();
		burst = {8'hc2, 8'h80, 8'hdf, 8'hbf, 8'he2, 8'h80, 8'ha8, 8'he2, 8'h81, 8'ha6,
			8'hf4, 8'h8f, 8'hbf, 8'hbf};
		send_burst(1'b0, 0);
	endtask

	// overlong, surrogate, invalid leads, flush of a truncated four-byte sequence at text end
	task automatic test_errors();
		burst = {8'he0, 8'h9f, 8'hed, 8'ha0, 8'hff, 8'hc1, 8'hf2, 8'h80, 8'h80};
		send_burst(1'b1, 0);
	endtask

	task automatic test_random(input int unsigned count);
		int unsigned start;
		start = bytes_sent;
		while (bytes_sent - start < count) begin
			make_unit();
			send_burst(1'b0, 4);
		end
	endtask

	task automatic test_streaming();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		test_random(60);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	always @(posedge clk) begin : check_output
		out_item_t want;
		if (arst_n && safe_valid && !safe_stall) begin
			if (expected_out.size() == 0) begin
				report_mismatch($sformatf("unexpected output byte %02h", safe.out_byte));
			end else begin
				want = expected_out.pop_front();
				if (safe.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						safe.out_byte, want.out_byte));
				if (safe.run_last !== want.run_last)
					report_mismatch($sformatf("run_last %b, expected %b",
						safe.run_last, want.run_last));
				if (safe.text_done !== want.text_done)
					report_mismatch($sformatf("text_done %b, expected %b",
						safe.text_done, want.text_done));
			end
		end
		safe_stall <= stalls_on && ($urandom_range(0, 99) < 33);
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_controls();
		test_sequences();
		test_errors();
		test_streaming();
		test_random(130);
		raw_valid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
